@@ src/point_store_geometric_predicates_macros.svh @@
// Assertion helpers, clocked on aclk and quiet during reset.
`ifndef POINT_STORE_GEOMETRIC_PREDICATES_MACROS_SVH
`define POINT_STORE_GEOMETRIC_PREDICATES_MACROS_SVH

`define PSGP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define PSGP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/psgp_pkg.sv @@
package psgp_pkg;
    localparam int POINT_CAPACITY = 1024;
    localparam int COORD_BITS     = 16;
    localparam int ADDR_W  = $clog2(POINT_CAPACITY);
    localparam int CNT_W   = $clog2(POINT_CAPACITY + 1);
    localparam int IDX_W   = 11;
    localparam int WORD_W  = 2 * COORD_BITS;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int EDIFF_W = COORD_BITS + 2;
    localparam int PROD_W  = 2 * COORD_BITS + 3;
    localparam int QW      = 2 * COORD_BITS + 4;
    localparam int LO_W    = QW / 2;
    localparam int MA_W    = QW;
    localparam int MB_W    = LO_W + 1;
    localparam int ACC_W   = 2 * QW + 2;

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_TRI  = 2'd1;
    localparam logic [1:0] MODE_CIRC = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    localparam logic [1:0] LOC_OUT    = 2'd0;
    localparam logic [1:0] LOC_BORDER = 2'd1;
    localparam logic [1:0] LOC_IN     = 2'd2;

    localparam logic [2:0] EDGE_NONE   = 3'd0;
    localparam logic [2:0] EDGE_VERTEX = 3'd1;
    localparam logic [2:0] EDGE_AB     = 3'd2;
    localparam logic [2:0] EDGE_BC     = 3'd3;
    localparam logic [2:0] EDGE_CA     = 3'd4;

    typedef struct packed {
        logic en;
        logic clr;
        logic sub;
        logic shift;
    } mac_ctl_t;
endpackage

@@ src/psgp_ram.sv @@
module psgp_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/psgp_mac.sv @@
module psgp_mac (
    input  logic                               aclk,
    input  psgp_pkg::mac_ctl_t                 ctl,
    input  logic signed [psgp_pkg::MA_W-1:0]   a,
    input  logic signed [psgp_pkg::MB_W-1:0]   b,
    output logic signed [psgp_pkg::ACC_W-1:0]  acc
);
    logic signed [psgp_pkg::MA_W+psgp_pkg::MB_W-1:0] prod;
    logic signed [psgp_pkg::ACC_W-1:0] term;
    logic signed [psgp_pkg::ACC_W-1:0] base;

    always_comb begin
        prod = a * b;
        term = psgp_pkg::ACC_W'(prod);
        if (ctl.shift) begin
            term = term <<< psgp_pkg::LO_W;
        end
        base = ctl.clr ? '0 : acc;
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            acc <= ctl.sub ? base - term : base + term;
        end
    end
endmodule

@@ src/point_store_geometric_predicates.sv @@
// Four store reads on the single read port, then one shared 36x19 multiply-accumulate unit.
// One item at a time; the next beat is taken while a result waits at the output.
// Synchronous active-low reset clears the point count and control; store contents persist.
module point_store_geometric_predicates (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[1:0], point_x[17:2], point_y[33:18], first_vertex[44:34],
    // second_vertex[55:45], third_vertex[66:56], query_point[77:67]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // new_index[10:0], location[12:11], edge_code[15:13], error[16]
    output logic [23:0] m_tdata
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_DIFF, ST_MUL, ST_DECIDE, ST_DONE
    } state_t;

    localparam int C = psgp_pkg::COORD_BITS;

    state_t state_reg, state_next;
    logic [psgp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [2:0] rd_reg, rd_next;
    logic [3:0] step_reg, step_next;

    logic [1:0] mode_in;
    logic [psgp_pkg::IDX_W-1:0] i1, i2, i3, iq;
    logic ok_all, in_acc;

    logic we;
    logic [psgp_pkg::ADDR_W-1:0] raddr;
    logic [psgp_pkg::WORD_W-1:0] rdata;

    logic [psgp_pkg::ADDR_W-1:0] addr_reg [4];
    logic [psgp_pkg::WORD_W-1:0] pt_reg [4];
    logic [1:0] qmode_reg;
    logic vmatch_reg;
    logic signed [psgp_pkg::DIFF_W-1:0] v0x, v0y, v1x, v1y, vx, vy;
    logic signed [psgp_pkg::EDIFF_W-1:0] e0x, e0y, ex, ey;
    logic signed [psgp_pkg::PROD_W-1:0] d_reg, s_reg, t_reg;
    logic signed [psgp_pkg::QW-1:0] nv_reg, coef_reg, crx;
    logic signed [psgp_pkg::ACC_W-1:0] e_reg, acc;

    logic [psgp_pkg::IDX_W-1:0] r_idx_reg, r_idx_next;
    logic [1:0] r_loc_reg, r_loc_next;
    logic [2:0] r_edge_reg, r_edge_next;
    logic r_err_reg, r_err_next;
    logic [23:0] m_data_reg;

    psgp_pkg::mac_ctl_t ctl;
    logic signed [psgp_pkg::MA_W-1:0] mul_a;
    logic signed [psgp_pkg::MB_W-1:0] mul_b;
    logic [3:0] last_step;

    logic signed [psgp_pkg::PROD_W+1:0] r_all, r_s, r_t;
    logic us_pos, ws_pos, dneg;

    function automatic logic idx_ok(input logic [psgp_pkg::IDX_W-1:0] idx,
                                    input logic [psgp_pkg::CNT_W-1:0] cnt);
        idx_ok = (idx != '0) &&
                 ((psgp_pkg::IDX_W+psgp_pkg::CNT_W)'(idx) <=
                  (psgp_pkg::IDX_W+psgp_pkg::CNT_W)'(cnt));
    endfunction

    function automatic logic signed [psgp_pkg::DIFF_W-1:0] cx_of(
            input logic [psgp_pkg::WORD_W-1:0] w, input logic hi);
        logic signed [C-1:0] v;
        v = hi ? $signed(w[2*C-1:C]) : $signed(w[C-1:0]);
        cx_of = psgp_pkg::DIFF_W'(v);
    endfunction

    assign mode_in = s_tdata[1:0];
    assign i1 = s_tdata[44:34];
    assign i2 = s_tdata[55:45];
    assign i3 = s_tdata[66:56];
    assign iq = s_tdata[77:67];
    assign ok_all = idx_ok(i1, cnt_reg) && idx_ok(i2, cnt_reg) &&
                    idx_ok(i3, cnt_reg) && idx_ok(iq, cnt_reg);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc = s_tvalid && s_tready;
    assign we = in_acc && (mode_in == psgp_pkg::MODE_ADD) &&
                (cnt_reg != psgp_pkg::CNT_W'(psgp_pkg::POINT_CAPACITY));
    assign raddr = addr_reg[rd_reg[1:0]];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_data_reg;
    assign last_step = (qmode_reg == psgp_pkg::MODE_TRI) ? 4'd6 : 4'd12;
    assign crx = psgp_pkg::QW'(t_reg);

    psgp_ram #(.DEPTH(psgp_pkg::POINT_CAPACITY), .WIDTH(psgp_pkg::WORD_W)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (cnt_reg[psgp_pkg::ADDR_W-1:0]),
        .wdata ({s_tdata[18+C-1:18], s_tdata[2+C-1:2]}),
        .raddr (raddr),
        .rdata (rdata)
    );

    psgp_mac u_mac (
        .aclk (aclk),
        .ctl  (ctl),
        .a    (mul_a),
        .b    (mul_b),
        .acc  (acc)
    );

    always_comb begin
        ctl = '0;
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL) begin
            ctl.en = 1'b1;
            case (step_reg)
                4'd0: begin ctl.clr = 1'b1; mul_a = psgp_pkg::MA_W'(v0x);
                    mul_b = psgp_pkg::MB_W'(v1y); end
                4'd1: begin ctl.sub = 1'b1; mul_a = psgp_pkg::MA_W'(v0y);
                    mul_b = psgp_pkg::MB_W'(v1x); end
                4'd2: begin
                    ctl.clr = 1'b1;
                    if (qmode_reg == psgp_pkg::MODE_TRI) begin
                        mul_a = psgp_pkg::MA_W'(v0x); mul_b = psgp_pkg::MB_W'(vy);
                    end else begin
                        mul_a = psgp_pkg::MA_W'(vx); mul_b = psgp_pkg::MB_W'(ex);
                    end
                end
                4'd3: begin
                    if (qmode_reg == psgp_pkg::MODE_TRI) begin
                        ctl.sub = 1'b1;
                        mul_a = psgp_pkg::MA_W'(v0y); mul_b = psgp_pkg::MB_W'(vx);
                    end else begin
                        mul_a = psgp_pkg::MA_W'(vy); mul_b = psgp_pkg::MB_W'(ey);
                    end
                end
                4'd4: begin
                    ctl.clr = 1'b1;
                    if (qmode_reg == psgp_pkg::MODE_TRI) begin
                        mul_a = psgp_pkg::MA_W'(vx); mul_b = psgp_pkg::MB_W'(v1y);
                    end else begin
                        mul_a = psgp_pkg::MA_W'(v0x); mul_b = psgp_pkg::MB_W'(e0x);
                    end
                end
                4'd5: begin
                    if (qmode_reg == psgp_pkg::MODE_TRI) begin
                        ctl.sub = 1'b1;
                        mul_a = psgp_pkg::MA_W'(vy); mul_b = psgp_pkg::MB_W'(v1x);
                    end else begin
                        mul_a = psgp_pkg::MA_W'(v0y); mul_b = psgp_pkg::MB_W'(e0y);
                    end
                end
                4'd6: begin
                    ctl.en = (qmode_reg != psgp_pkg::MODE_TRI);
                    ctl.clr = 1'b1;
                    mul_a = psgp_pkg::MA_W'(v1x); mul_b = psgp_pkg::MB_W'(vy);
                end
                4'd7: begin ctl.sub = 1'b1; mul_a = psgp_pkg::MA_W'(v1y);
                    mul_b = psgp_pkg::MB_W'(vx); end
                4'd8: begin
                    ctl.clr = 1'b1; ctl.sub = 1'b1;
                    mul_a = psgp_pkg::MA_W'(d_reg);
                    mul_b = $signed({1'b0, nv_reg[psgp_pkg::LO_W-1:0]});
                end
                4'd9: begin
                    ctl.sub = 1'b1; ctl.shift = 1'b1;
                    mul_a = psgp_pkg::MA_W'(d_reg);
                    mul_b = psgp_pkg::MB_W'($signed(nv_reg[psgp_pkg::QW-1:psgp_pkg::LO_W]));
                end
                4'd10: begin
                    ctl.sub = 1'b1;
                    mul_a = coef_reg;
                    mul_b = $signed({1'b0, crx[psgp_pkg::LO_W-1:0]});
                end
                4'd11: begin
                    ctl.sub = 1'b1; ctl.shift = 1'b1;
                    mul_a = coef_reg;
                    mul_b = psgp_pkg::MB_W'($signed(crx[psgp_pkg::QW-1:psgp_pkg::LO_W]));
                end
                default: ctl.en = 1'b0;
            endcase
        end
    end

    always_comb begin
        dneg = d_reg < 0;
        r_all = (psgp_pkg::PROD_W+2)'(d_reg) - (psgp_pkg::PROD_W+2)'(s_reg) -
                (psgp_pkg::PROD_W+2)'(t_reg);
        r_s = (psgp_pkg::PROD_W+2)'(d_reg) - (psgp_pkg::PROD_W+2)'(s_reg);
        r_t = (psgp_pkg::PROD_W+2)'(d_reg) - (psgp_pkg::PROD_W+2)'(t_reg);
        us_pos = (t_reg != 0) && ((t_reg < 0) == dneg);
        ws_pos = (s_reg != 0) && ((s_reg < 0) == dneg);
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        rd_next = rd_reg;
        step_next = step_reg;
        r_idx_next = r_idx_reg;
        r_loc_next = r_loc_reg;
        r_edge_next = r_edge_reg;
        r_err_next = r_err_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    r_idx_next = '0;
                    r_loc_next = psgp_pkg::LOC_OUT;
                    r_edge_next = psgp_pkg::EDGE_NONE;
                    r_err_next = 1'b0;
                    rd_next = '0;
                    state_next = ST_DONE;
                    if (mode_in == psgp_pkg::MODE_ADD) begin
                        if (we) begin
                            cnt_next = cnt_reg + 1'b1;
                            r_idx_next = psgp_pkg::IDX_W'(cnt_next);
                        end else begin
                            r_err_next = 1'b1;
                        end
                    end else if ((mode_in == psgp_pkg::MODE_TRI ||
                                  mode_in == psgp_pkg::MODE_CIRC) && ok_all) begin
                        state_next = ST_READ;
                    end else begin
                        r_err_next = 1'b1;
                    end
                end
            end
            ST_READ: begin
                rd_next = rd_reg + 1'b1;
                if (rd_reg == 3'd4) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                step_next = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                step_next = step_reg + 1'b1;
                if (step_reg == last_step) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                r_edge_next = psgp_pkg::EDGE_NONE;
                r_loc_next = psgp_pkg::LOC_OUT;
                if (qmode_reg == psgp_pkg::MODE_TRI && vmatch_reg) begin
                    r_loc_next = psgp_pkg::LOC_BORDER;
                    r_edge_next = psgp_pkg::EDGE_VERTEX;
                end else if (d_reg == 0) begin
                    r_loc_next = psgp_pkg::LOC_BORDER;
                end else if (qmode_reg == psgp_pkg::MODE_TRI) begin
                    if (us_pos && ws_pos) begin
                        if (r_all == 0) begin
                            r_loc_next = psgp_pkg::LOC_BORDER;
                            r_edge_next = psgp_pkg::EDGE_BC;
                        end else if ((r_all < 0) == dneg) begin
                            r_loc_next = psgp_pkg::LOC_IN;
                        end
                    end else if (t_reg == 0) begin
                        if (ws_pos && r_s != 0 && ((r_s < 0) == dneg)) begin
                            r_loc_next = psgp_pkg::LOC_BORDER;
                            r_edge_next = psgp_pkg::EDGE_CA;
                        end
                    end else if (s_reg == 0) begin
                        if (us_pos && r_t != 0 && ((r_t < 0) == dneg)) begin
                            r_loc_next = psgp_pkg::LOC_BORDER;
                            r_edge_next = psgp_pkg::EDGE_AB;
                        end
                    end
                end else begin
                    if (e_reg == 0) begin
                        r_loc_next = psgp_pkg::LOC_BORDER;
                    end else if ((e_reg < 0) == dneg) begin
                        r_loc_next = psgp_pkg::LOC_IN;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
            rd_reg <= '0;
            step_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_reg <= rd_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_idx_reg <= r_idx_next;
        r_loc_reg <= r_loc_next;
        r_edge_reg <= r_edge_next;
        r_err_reg <= r_err_next;
        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
            m_data_reg <= {7'd0, r_err_reg, r_edge_reg, r_loc_reg, r_idx_reg};
        end
        if (in_acc) begin
            qmode_reg <= mode_in;
            addr_reg[0] <= psgp_pkg::ADDR_W'(i1 - 1'b1);
            addr_reg[1] <= psgp_pkg::ADDR_W'(i2 - 1'b1);
            addr_reg[2] <= psgp_pkg::ADDR_W'(i3 - 1'b1);
            addr_reg[3] <= psgp_pkg::ADDR_W'(iq - 1'b1);
        end
        if (state_reg == ST_READ && rd_reg != 3'd0) begin
            pt_reg[2'(rd_reg - 1'b1)] <= rdata;
        end
        if (state_reg == ST_DIFF) begin
            vmatch_reg <= (pt_reg[3] == pt_reg[0]) || (pt_reg[3] == pt_reg[1]) ||
                          (pt_reg[3] == pt_reg[2]);
            v0x <= cx_of(pt_reg[1], 1'b0) - cx_of(pt_reg[0], 1'b0);
            v0y <= cx_of(pt_reg[1], 1'b1) - cx_of(pt_reg[0], 1'b1);
            v1x <= cx_of(pt_reg[2], 1'b0) - cx_of(pt_reg[0], 1'b0);
            v1y <= cx_of(pt_reg[2], 1'b1) - cx_of(pt_reg[0], 1'b1);
            vx  <= cx_of(pt_reg[3], 1'b0) - cx_of(pt_reg[0], 1'b0);
            vy  <= cx_of(pt_reg[3], 1'b1) - cx_of(pt_reg[0], 1'b1);
            e0x <= psgp_pkg::EDIFF_W'(cx_of(pt_reg[1], 1'b0)) -
                   psgp_pkg::EDIFF_W'(cx_of(pt_reg[2], 1'b0));
            e0y <= psgp_pkg::EDIFF_W'(cx_of(pt_reg[1], 1'b1)) -
                   psgp_pkg::EDIFF_W'(cx_of(pt_reg[2], 1'b1));
            ex  <= psgp_pkg::EDIFF_W'(cx_of(pt_reg[3], 1'b0)) -
                   psgp_pkg::EDIFF_W'(cx_of(pt_reg[2], 1'b0));
            ey  <= psgp_pkg::EDIFF_W'(cx_of(pt_reg[3], 1'b1)) -
                   psgp_pkg::EDIFF_W'(cx_of(pt_reg[2], 1'b1));
        end
        if (state_reg == ST_MUL) begin
            case (step_reg)
                4'd2: d_reg <= psgp_pkg::PROD_W'(acc);
                4'd4: begin
                    if (qmode_reg == psgp_pkg::MODE_TRI) begin
                        s_reg <= psgp_pkg::PROD_W'(acc);
                    end else begin
                        nv_reg <= psgp_pkg::QW'(acc);
                    end
                end
                4'd6: begin
                    if (qmode_reg == psgp_pkg::MODE_TRI) begin
                        t_reg <= psgp_pkg::PROD_W'(acc);
                    end else begin
                        coef_reg <= psgp_pkg::QW'(acc);
                    end
                end
                4'd8: t_reg <= psgp_pkg::PROD_W'(acc);
                4'd12: e_reg <= acc;
                default: ;
            endcase
        end
    end

    `include "point_store_geometric_predicates_macros.svh"

    `PSGP_ASSERT_NEXT(a_one_item, in_acc, !s_tready, "second beat taken while busy")
    `PSGP_ASSERT_NEXT(a_count_step, we, cnt_reg == $past(cnt_reg) + 1'b1,
        "point count did not advance on add")
    `PSGP_ASSERT_SAME(a_count_cap,
        state_reg == ST_IDLE,
        cnt_reg <= psgp_pkg::CNT_W'(psgp_pkg::POINT_CAPACITY), "point count above capacity")
    `PSGP_ASSERT_SAME(a_add_result, m_tvalid && m_tdata[10:0] != 11'd0,
        m_tdata[12:11] == psgp_pkg::LOC_OUT && !m_tdata[16], "add result carries query fields")
endmodule
